FILE: rtl/core/ccfe_pkg.sv
// Package for the CRC-16 COBS frame encoder: item types, the command word
// passed from the front part to the back part, constants and the CRC step.
// No dependencies.
`default_nettype none

package ccfe_pkg;

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [7:0]  RUN_MAX     = 8'hFF;
	localparam logic [10:0] LIMIT_MIN   = 11'd2;
	localparam logic [10:0] LIMIT_RESET = 11'd1024;
	localparam int          MAX_FRAME   = 1024;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic [10:0] write_addr;
		logic [7:0]  write_value;
		logic        frame_done;
		logic [10:0] frame_length;
		logic        status;
	} out_item_t;

	// One accepted input word as the back part needs it.
	typedef struct packed {
		logic [7:0]  data;
		logic        use_byte;
		logic        last;
		logic [15:0] crc;
		logic        ovf;
	} cmd_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/ccfe_fifo.sv
// Small register-based first-in first-out queue with a registered count.
// Depends on nothing; used between the front and back parts and at the output.
`default_nettype none

module ccfe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ccfe_front.sv
// Front part: takes payload words, holds the frame limit, runs the CRC and
// decides which bytes fit. Depends on ccfe_pkg.
`default_nettype none

module ccfe_front
	import ccfe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        frame_limit_we,
	input  wire logic [10:0] frame_limit,
	input  wire logic        push,
	input  wire in_item_t    payload,
	output logic             full,
	output logic             cmd_push,
	output cmd_t             cmd,
	input  wire logic        cmd_full
);

	logic [10:0] frame_limit_q;
	logic [15:0] crc_q;
	logic [10:0] byte_count_q;
	logic        overflowed_q;
	logic [10:0] limit;
	logic        fits;
	logic        accept;
	logic [15:0] crc_new;

	always_comb begin
		if (frame_limit_q < LIMIT_MIN) begin
			limit = LIMIT_MIN;
		end else if (32'(frame_limit_q) > MAX_FRAME) begin
			limit = 11'(MAX_FRAME);
		end else begin
			limit = frame_limit_q;
		end
	end

	// Two places are always kept free for the CRC bytes.
	assign fits    = ({1'b0, byte_count_q} + 12'd3) <= {1'b0, limit};
	assign crc_new = fits ? crc_byte(crc_q, payload.data_byte) : crc_q;
	assign full    = cmd_full;
	assign accept  = push && !cmd_full;

	assign cmd_push     = accept && (fits || payload.frame_end);
	assign cmd.data     = payload.data_byte;
	assign cmd.use_byte = fits;
	assign cmd.last     = payload.frame_end;
	assign cmd.crc      = crc_new;
	assign cmd.ovf      = overflowed_q || !fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_limit_q <= LIMIT_RESET;
			crc_q         <= CRC_INIT;
			byte_count_q  <= '0;
			overflowed_q  <= 1'b0;
		end else begin
			if (frame_limit_we) begin
				frame_limit_q <= frame_limit;
			end
			if (accept) begin
				if (payload.frame_end) begin
					crc_q        <= CRC_INIT;
					byte_count_q <= '0;
					overflowed_q <= 1'b0;
				end else begin
					crc_q        <= crc_new;
					byte_count_q <= byte_count_q + 11'(fits);
					overflowed_q <= overflowed_q || !fits;
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/ccfe_back.sv
// Back part: COBS stuffing of queued words, one memory write per cycle unless
// stalled, with code-byte write-back and the frame trailer. Depends on ccfe_pkg.
`default_nettype none

module ccfe_back
	import ccfe_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_empty,
	input  wire cmd_t  cmd,
	output logic       cmd_pop,
	output logic       out_push,
	output out_item_t  out_item,
	input  wire logic  out_full
);

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_BYTE   = 6'b000010,
		PH_CRC_HI = 6'b000100,
		PH_CRC_LO = 6'b001000,
		PH_CODE   = 6'b010000,
		PH_TERM   = 6'b100000
	} phase_t;

	phase_t      phase_q, phase_d, eff_phase, adv_phase;
	logic [7:0]  run_code_q, run_code_d;
	logic [10:0] code_slot_q, code_slot_d;
	logic [10:0] next_slot_q, next_slot_d;
	logic        close_pend_q, close_pend_d;
	logic        go;
	logic        adv_pop;
	logic [7:0]  stuff_b;

	assign go = !cmd_empty && !out_full;

	// A new word starts at its payload byte, or at the CRC if the byte was dropped.
	assign eff_phase = (phase_q == PH_IDLE) ? (cmd.use_byte ? PH_BYTE : PH_CRC_HI) : phase_q;

	always_comb begin
		adv_pop   = 1'b0;
		adv_phase = PH_CODE;
		stuff_b   = cmd.crc[7:0];
		unique case (eff_phase)
			PH_BYTE: begin
				stuff_b   = cmd.data;
				adv_phase = cmd.last ? PH_CRC_HI : PH_IDLE;
				adv_pop   = !cmd.last;
			end
			PH_CRC_HI: begin
				stuff_b   = cmd.crc[15:8];
				adv_phase = PH_CRC_LO;
			end
			PH_CRC_LO: begin
				stuff_b   = cmd.crc[7:0];
				adv_phase = PH_CODE;
			end
			default: begin
				adv_phase = PH_CODE;
			end
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		run_code_d   = run_code_q;
		code_slot_d  = code_slot_q;
		next_slot_d  = next_slot_q;
		close_pend_d = close_pend_q;
		cmd_pop      = 1'b0;
		out_push     = 1'b0;
		out_item.write_addr   = code_slot_q;
		out_item.write_value  = run_code_q;
		out_item.frame_done   = 1'b0;
		out_item.frame_length = '0;
		out_item.status       = cmd.ovf;
		if (go) begin
			out_push = 1'b1;
			unique case (eff_phase) inside
				PH_BYTE, PH_CRC_HI, PH_CRC_LO: begin
					if (close_pend_q || stuff_b == 8'h00) begin
						// Close the block: its code goes back to the reserved slot.
						code_slot_d  = next_slot_q;
						next_slot_d  = next_slot_q + 1'b1;
						run_code_d   = 8'd1;
						close_pend_d = 1'b0;
						phase_d      = adv_phase;
						cmd_pop      = adv_pop;
					end else begin
						out_item.write_addr  = next_slot_q;
						out_item.write_value = stuff_b;
						next_slot_d = next_slot_q + 1'b1;
						run_code_d  = run_code_q + 1'b1;
						if (run_code_q + 1'b1 == RUN_MAX) begin
							close_pend_d = 1'b1;
							phase_d      = eff_phase;
						end else begin
							phase_d = adv_phase;
							cmd_pop = adv_pop;
						end
					end
				end
				PH_CODE: begin
					phase_d = PH_TERM;
				end
				PH_TERM: begin
					out_item.write_addr   = next_slot_q;
					out_item.write_value  = 8'h00;
					out_item.frame_done   = 1'b1;
					out_item.frame_length = next_slot_q + 1'b1;
					run_code_d  = 8'd1;
					code_slot_d = '0;
					next_slot_d = 11'd1;
					phase_d     = PH_IDLE;
					cmd_pop     = 1'b1;
				end
				default: begin
					out_push = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			run_code_q   <= 8'd1;
			code_slot_q  <= '0;
			next_slot_q  <= 11'd1;
			close_pend_q <= 1'b0;
		end else begin
			phase_q      <= phase_d;
			run_code_q   <= run_code_d;
			code_slot_q  <= code_slot_d;
			next_slot_q  <= next_slot_d;
			close_pend_q <= close_pend_d;
		end
	end

	a_pop_with_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> out_push)
		else $error("queue word retired without a write");

	a_done_retires: assert property (@(posedge clk) disable iff (!arst_n)
		(out_push && out_item.frame_done) |-> (cmd_pop && cmd.last))
		else $error("terminator written without retiring the last word");

	a_pend_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		close_pend_q |-> (run_code_q == RUN_MAX))
		else $error("pending close without a full run");

	a_pend_after_data: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(close_pend_q) |-> $past(out_push) && !$past(cmd_pop))
		else $error("pending close raised without a data write");

endmodule

`default_nettype wire

FILE: rtl/core/crc16_cobs_frame_encoder.sv
// Top level of the CRC-16 COBS frame encoder: front part, command queue,
// back part and result queue. Depends on ccfe_pkg, ccfe_fifo, ccfe_front, ccfe_back.
//
// Channel        Direction  Handshake          Word
// payload        in         push / full        in_item_t (data_byte, frame_end)
// result         out        pop / empty        out_item_t (write_addr .. status)
// frame_limit    in         frame_limit_we     11-bit limit, no read-back
//
// The front takes one word per cycle while the command queue has room; the
// CRC byte step is done in that same cycle.
// The back makes one memory write per cycle unless it stalls; a byte closing a run
// of 254 adds its code-byte write, a frame end the CRC, code-byte and zero writes.
// The back stalls only on a full result queue; the front only on a full command queue.
// Reset is asynchronous, active low; after it the limit is 1024 and no frame is open.
`default_nettype none

module crc16_cobs_frame_encoder
	import ccfe_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        frame_limit_we,
	input  wire logic [10:0] frame_limit,
	input  wire logic        push,
	input  wire in_item_t    payload,
	output logic             full,
	input  wire logic        pop,
	output out_item_t        result,
	output logic             empty
);

	logic      cmd_push;
	cmd_t      cmd_in;
	logic      cmd_full;
	logic      cmd_pop;
	cmd_t      cmd_head;
	logic      cmd_empty;
	logic      out_push;
	out_item_t out_item;
	logic      out_full;

	ccfe_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_limit_we (frame_limit_we),
		.frame_limit    (frame_limit),
		.push           (push),
		.payload        (payload),
		.full           (full),
		.cmd_push       (cmd_push),
		.cmd            (cmd_in),
		.cmd_full       (cmd_full)
	);

	ccfe_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_head),
		.empty  (cmd_empty)
	);

	ccfe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.out_push  (out_push),
		.out_item  (out_item),
		.out_full  (out_full)
	);

	ccfe_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (2)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule

`default_nettype wire
